/* sv/ctr_pkg.sv */
package ctr_pkg;

    // sizes of the tag store
    localparam int MAX_LINES  = 256;
    localparam int WAYS       = 4;
    localparam int ADDR_W     = 32;
    localparam int LINE_W     = $clog2(MAX_LINES);
    localparam int WAY_W      = $clog2(WAYS);
    localparam int SET_N      = MAX_LINES / WAYS;
    localparam int SET_W      = LINE_W - WAY_W;
    localparam int CNT_W      = LINE_W + 1;
    localparam int TAG_W      = 32;
    localparam int RANK_W     = LINE_W;

    // configuration port
    localparam int MODE_W     = 2;
    localparam int OFS_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINES  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_DIRECT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIFO4  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LRU    = 2'd2;

    localparam logic [OFS_W-1:0] RST_OFFSET = 4'd4;
    localparam logic [OFS_W-1:0] RST_LINES  = 4'd8;

    // control into the compare unit
    typedef struct packed {
        logic clr;
        logic vld;
        logic by_rank;
    } t_scan_ctl;

    // what one pass over the lines found
    typedef struct packed {
        logic              hit;
        logic [LINE_W-1:0] hit_line;
        logic [RANK_W-1:0] hit_rank;
        logic              empty;
        logic [LINE_W-1:0] empty_line;
        logic [LINE_W-1:0] victim_line;
        logic [TAG_W-1:0]  victim_tag;
    } t_scan_res;

endpackage

/* sv/ctr_ram.sv */
module ctr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/ctr_scan.sv */
module ctr_scan
    import ctr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_scan_ctl         i_ctl,
    input  logic [LINE_W-1:0] i_line,
    input  logic              i_valid,
    input  logic [TAG_W-1:0]  i_tag,
    input  logic [RANK_W-1:0] i_rank,
    input  logic [TAG_W-1:0]  i_key,
    input  logic [LINE_W-1:0] i_fixed,
    output t_scan_res         o_res
);

    t_scan_res         r_res;
    logic [RANK_W-1:0] r_max;
    logic              r_any;

    // shared compare unit: one line per cycle, while i_ctl.vld is set, folded into the running result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_res.hit   <= 1'b0;
            r_res.empty <= 1'b0;
            r_any       <= 1'b0;
        end else if (i_ctl.vld) begin
            // first valid line whose tag matches
            if (!r_res.hit && i_valid && (i_tag == i_key)) begin
                r_res.hit      <= 1'b1;
                r_res.hit_line <= i_line;
                r_res.hit_rank <= i_rank;
            end
            // first empty line
            if (!r_res.empty && !i_valid) begin
                r_res.empty      <= 1'b1;
                r_res.empty_line <= i_line;
            end
            // victim: oldest by rank, or the line chosen up front
            if (i_ctl.by_rank) begin
                if (!r_any || (i_rank > r_max)) begin
                    r_any             <= 1'b1;
                    r_max             <= i_rank;
                    r_res.victim_line <= i_line;
                    r_res.victim_tag  <= i_tag;
                end
            end else if (i_line == i_fixed) begin
                r_res.victim_line <= i_line;
                r_res.victim_tag  <= i_tag;
            end
        end
    end

    assign o_res = r_res;

endmodule

/* sv/cache_tag_replacement_model.sv */
// a new item can be taken in the o_done cycle; n below is the number of lines in use.
// the tag and rank memories give one line per cycle through the shared compare unit;
// fully associative mode walks all n lines twice (search, then rank update).
// synchronous active-low reset clears valid bits at once, no sweep; a set's fifo pointer
// is written to zero when its first way fills, so it needs no clearing. any write to a known
// configuration register flushes the store the same way. results cannot be stalled.
module cache_tag_replacement_model
    import ctr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [ADDR_W-1:0]     i_address,
    output logic                  o_done,
    output logic                  o_evicted,
    output logic [TAG_W-1:0]      o_evicted_tag,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_SCAN   = 6'b000100,
        S_DECIDE = 6'b001000,
        S_UPDATE = 6'b010000,
        S_OFF    = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [MODE_W-1:0]  r_mode;
    logic [OFS_W-1:0]   r_ofs;
    logic [OFS_W-1:0]   r_lines;

    logic [MAX_LINES-1:0] r_valid;

    logic [ADDR_W-1:0]  r_block;
    logic [TAG_W-1:0]   r_key;
    logic [LINE_W-1:0]  r_base;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_total;
    logic               r_rd_vld;
    logic [LINE_W-1:0]  r_rd_line;
    logic [LINE_W-1:0]  r_target;
    logic               r_miss;
    logic [RANK_W-1:0]  r_hr;

    logic               r_done;
    logic               r_ev;
    logic [TAG_W-1:0]   r_evtag;

    logic [OFS_W-1:0]   s_l;
    logic [OFS_W-1:0]   s_sh;
    logic [CNT_W-1:0]   s_n;
    logic [LINE_W-1:0]  s_lmask;
    logic [LINE_W-1:0]  s_line;
    logic [LINE_W-1:0]  s_fixed;
    logic [SET_W-1:0]   s_set;
    logic               s_issue;
    logic               s_accept;

    logic [TAG_W-1:0]   s_tag_q;
    logic [RANK_W-1:0]  s_rank_q;
    logic               s_tag_we;
    logic [LINE_W-1:0]  s_tag_waddr;
    logic               s_rank_we;
    logic [RANK_W-1:0]  s_rank_wdata;
    logic [WAY_W-1:0]   s_fill_q;
    logic               s_fill_we;
    logic [WAY_W-1:0]   s_fill_wdata;

    t_scan_ctl          s_ctl;
    t_scan_res          s_res;

    assign s_accept = i_start && !o_busy;

    // lines in use, clamped to the store size and at least one set of four
    always_comb begin
        if (r_lines > OFS_W'(LINE_W)) begin
            s_l = OFS_W'(LINE_W);
        end else if (r_lines < OFS_W'(WAY_W)) begin
            s_l = OFS_W'(WAY_W);
        end else begin
            s_l = r_lines;
        end
    end

    assign s_n     = CNT_W'(1) << s_l;
    assign s_lmask = LINE_W'(s_n - CNT_W'(1));

    // tag shift per mode
    always_comb begin
        case (r_mode)
            MODE_DIRECT: s_sh = s_l;
            MODE_FIFO4:  s_sh = s_l - OFS_W'(WAY_W);
            default:     s_sh = '0;
        endcase
    end

    assign s_set   = r_base[LINE_W-1:WAY_W];
    assign s_fixed = (r_mode == MODE_FIFO4) ? (r_base | LINE_W'(s_fill_q)) : r_base;

    // line read this cycle
    always_comb begin
        case (r_mode)
            MODE_DIRECT: s_line = r_base;
            MODE_FIFO4:  s_line = r_base | LINE_W'(r_cnt[WAY_W-1:0]);
            default:     s_line = r_cnt[LINE_W-1:0];
        endcase
    end

    assign s_issue = ((r_state == S_SCAN) || (r_state == S_UPDATE)) && (r_cnt < r_total);

    // memories
    ctr_ram #(.WIDTH(TAG_W), .DEPTH(MAX_LINES)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (s_tag_we),
        .i_waddr (s_tag_waddr),
        .i_wdata (r_key),
        .i_raddr (s_line),
        .o_rdata (s_tag_q)
    );

    ctr_ram #(.WIDTH(RANK_W), .DEPTH(MAX_LINES)) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (s_rank_we),
        .i_waddr (r_rd_line),
        .i_wdata (s_rank_wdata),
        .i_raddr (s_line),
        .o_rdata (s_rank_q)
    );

    // fifo pointer per set, read from the first scan cycle on
    ctr_ram #(.WIDTH(WAY_W), .DEPTH(SET_N)) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (s_fill_we),
        .i_waddr (s_set),
        .i_wdata (s_fill_wdata),
        .i_raddr (s_set),
        .o_rdata (s_fill_q)
    );

    // compare unit
    assign s_ctl.clr     = (r_state == S_DECODE);
    assign s_ctl.vld     = (r_state == S_SCAN) && r_rd_vld;
    assign s_ctl.by_rank = (r_mode == MODE_LRU);

    ctr_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s_ctl),
        .i_line  (r_rd_line),
        .i_valid (r_valid[r_rd_line]),
        .i_tag   (s_tag_q),
        .i_rank  (s_rank_q),
        .i_key   (r_key),
        .i_fixed (s_fixed),
        .o_res   (s_res)
    );

    // tag write at the decision
    always_comb begin
        s_tag_we    = 1'b0;
        s_tag_waddr = r_base;
        if (r_state == S_DECIDE) begin
            case (r_mode)
                MODE_DIRECT: begin
                    s_tag_we = 1'b1;
                end
                MODE_FIFO4: begin
                    s_tag_we    = !s_res.hit;
                    s_tag_waddr = s_res.empty ? s_res.empty_line : s_fixed;
                end
                MODE_LRU: begin
                    s_tag_we    = !s_res.hit;
                    s_tag_waddr = s_res.hit ? s_res.hit_line :
                                  s_res.empty ? s_res.empty_line : s_res.victim_line;
                end
                default: begin
                    s_tag_we = 1'b0;
                end
            endcase
        end
    end

    // fifo pointer: zero when way 0 of a set fills, step on each eviction
    assign s_fill_we    = (r_state == S_DECIDE) && (r_mode == MODE_FIFO4) && !s_res.hit &&
                          (!s_res.empty || (s_res.empty_line == r_base));
    assign s_fill_wdata = s_res.empty ? '0 : (s_fill_q + WAY_W'(1));

    // rank update: target goes to most recent, younger (hit) or all other valid (miss) lines age by one
    always_comb begin
        s_rank_we    = 1'b0;
        s_rank_wdata = s_rank_q + RANK_W'(1);
        if ((r_state == S_UPDATE) && r_rd_vld) begin
            if (r_rd_line == r_target) begin
                s_rank_we    = 1'b1;
                s_rank_wdata = '0;
            end else if (r_valid[r_rd_line] && (r_miss || (s_rank_q < r_hr))) begin
                s_rank_we = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (s_accept) n_state = S_DECODE;
            S_DECODE: n_state = (r_mode == MODE_LRU || r_mode == MODE_DIRECT ||
                                 r_mode == MODE_FIFO4) ? S_SCAN : S_OFF;
            S_SCAN:   if (r_cnt == r_total) n_state = S_DECIDE;
            S_DECIDE: n_state = (r_mode == MODE_LRU) ? S_UPDATE : S_IDLE;
            S_UPDATE: if (r_cnt == r_total) n_state = S_IDLE;
            S_OFF:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // access datapath: address split, counters and read pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_rd_vld <= s_issue;
            if (s_issue) begin
                r_cnt     <= r_cnt + CNT_W'(1);
                r_rd_line <= s_line;
            end
            if (s_accept) begin
                r_block <= i_address >> r_ofs;
            end
            if (r_state == S_DECODE) begin
                r_key <= TAG_W'(r_block >> s_sh);
                r_cnt <= '0;
                case (r_mode)
                    MODE_DIRECT: begin
                        r_base  <= r_block[LINE_W-1:0] & s_lmask;
                        r_total <= CNT_W'(1);
                    end
                    MODE_FIFO4: begin
                        r_base  <= (r_block[LINE_W-1:0] & (s_lmask >> WAY_W)) << WAY_W;
                        r_total <= CNT_W'(WAYS);
                    end
                    default: begin
                        r_base  <= '0;
                        r_total <= s_n;
                    end
                endcase
            end
            if (r_state == S_DECIDE) begin
                r_cnt    <= '0;
                r_miss   <= !s_res.hit;
                r_hr     <= s_res.hit_rank;
                r_target <= s_tag_waddr;
            end
        end
    end

    // result register, one cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_ev    <= 1'b0;
            r_evtag <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_state == S_OFF) begin
                r_done  <= 1'b1;
                r_ev    <= 1'b0;
                r_evtag <= '0;
            end else if (r_state == S_DECIDE) begin
                case (r_mode)
                    MODE_DIRECT: begin
                        r_done  <= 1'b1;
                        r_ev    <= r_valid[r_base] && !s_res.hit;
                        r_evtag <= (r_valid[r_base] && !s_res.hit) ? s_res.victim_tag : '0;
                    end
                    MODE_FIFO4: begin
                        r_done  <= 1'b1;
                        r_ev    <= !s_res.hit && !s_res.empty;
                        r_evtag <= (!s_res.hit && !s_res.empty) ? s_res.victim_tag : '0;
                    end
                    default: begin
                        // result goes out after the rank pass
                        r_ev    <= !s_res.hit && !s_res.empty;
                        r_evtag <= (!s_res.hit && !s_res.empty) ? s_res.victim_tag : '0;
                    end
                endcase
            end else if ((r_state == S_UPDATE) && (r_cnt == r_total)) begin
                r_done <= 1'b1;
            end
        end
    end

    // configuration and valid bits; any known write flushes the store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_DIRECT;
            r_ofs   <= RST_OFFSET;
            r_lines <= RST_LINES;
            r_valid <= '0;
        end else begin
            if (s_tag_we) begin
                r_valid[s_tag_waddr] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE: begin
                        r_mode  <= i_cfg_data[MODE_W-1:0];
                        r_valid <= '0;
                    end
                    CFG_OFFSET: begin
                        r_ofs   <= i_cfg_data[OFS_W-1:0];
                        r_valid <= '0;
                    end
                    CFG_LINES: begin
                        r_lines <= i_cfg_data[OFS_W-1:0];
                        r_valid <= '0;
                    end
                    default: begin
                        r_lines <= r_lines;
                    end
                endcase
            end
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_evicted     = r_ev;
    assign o_evicted_tag = r_evtag;

    // checks
    a_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_evicted) |-> (o_evicted_tag == '0))
        else $error("evicted tag not zero without eviction");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) || (r_state == S_UPDATE)) |-> (r_cnt <= r_total))
        else $error("line counter ran past the pass length");

    a_done_on_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> o_done)
        else $error("returned to idle without a result");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import ctr_pkg::*;

    // codes the package does not name
    localparam logic [MODE_W-1:0]    MODE_OFF   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS  = 1000;
    localparam int SETTLE_CYCLES = 2 * MAX_LINES + 8;
    localparam int STALL_LIMIT   = 4 * MAX_LINES + 1000;

    typedef struct packed {
        logic             evicted;
        logic [TAG_W-1:0] tag;
    } t_eviction;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_start = 1'b0;
    logic [ADDR_W-1:0]     i_address = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_busy;
    logic                  o_done;
    logic                  o_evicted;
    logic [TAG_W-1:0]      o_evicted_tag;

    // predicted tag store
    logic [TAG_W-1:0]  tag_mem   [MAX_LINES];
    bit                line_live [MAX_LINES];
    int unsigned       age_rank  [MAX_LINES];
    int unsigned       fill_ptr  [SET_N];
    logic [MODE_W-1:0] cfg_mode   = MODE_DIRECT;
    logic [OFS_W-1:0]  cfg_offset = RST_OFFSET;
    logic [OFS_W-1:0]  cfg_lines  = RST_LINES;

    t_eviction         eviction_q [$];
    logic [ADDR_W-1:0] addr_pool [$];
    int                fail_cnt = 0;
    int                stall_cycles = 0;
    int unsigned       items_sent = 0;

    cache_tag_replacement_model i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_address     (i_address),
        .o_done        (o_done),
        .o_evicted     (o_evicted),
        .o_evicted_tag (o_evicted_tag),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // clear the predicted store
    task automatic flush_store();
        for (int i = 0; i < MAX_LINES; i++) begin
            tag_mem[i]   = '0;
            line_live[i] = 1'b0;
            age_rank[i]  = 0;
        end
        for (int s = 0; s < SET_N; s++) begin
            fill_ptr[s] = 0;
        end
    endtask

    // log2 of lines in use, clamped
    function automatic int unsigned eff_lines();
        if (cfg_lines < 2) return 2;
        if (cfg_lines > LINE_W) return LINE_W;
        return 32'(cfg_lines);
    endfunction

    // work out what one access displaces and update the predicted store
    task automatic predict_eviction(input logic [ADDR_W-1:0] addr, output t_eviction res);
        logic [ADDR_W-1:0] block;
        logic [TAG_W-1:0]  tag;
        int unsigned       l;
        int unsigned       n;
        int unsigned       idx;
        int unsigned       set_no;
        int unsigned       base;
        int unsigned       hit_line;
        int unsigned       free_line;
        int unsigned       victim;
        int unsigned       r;
        res.evicted = 1'b0;
        res.tag     = '0;
        block = addr >> cfg_offset;
        l = eff_lines();
        n = 1 << l;
        case (cfg_mode)
            MODE_DIRECT: begin
                idx = block & (n - 1);
                tag = block >> l;
                if (line_live[idx] && tag_mem[idx] != tag) begin
                    res.evicted = 1'b1;
                    res.tag     = tag_mem[idx];
                end
                line_live[idx] = 1'b1;
                tag_mem[idx]   = tag;
            end
            MODE_FIFO4: begin
                set_no = block & ((1 << (l - 2)) - 1);
                tag = block >> (l - 2);
                base = set_no * WAYS;
                hit_line = WAYS;
                free_line = WAYS;
                for (int w = 0; w < WAYS; w++) begin
                    if (line_live[base + w] && tag_mem[base + w] == tag) hit_line = w;
                    if (!line_live[base + w] && free_line == WAYS) free_line = w;
                end
                if (hit_line == WAYS) begin
                    if (free_line < WAYS) begin
                        line_live[base + free_line] = 1'b1;
                        tag_mem[base + free_line]   = tag;
                    end else begin
                        victim = fill_ptr[set_no] % WAYS;
                        res.evicted = 1'b1;
                        res.tag     = tag_mem[base + victim];
                        tag_mem[base + victim] = tag;
                        fill_ptr[set_no] = (victim + 1) % WAYS;
                    end
                end
            end
            MODE_LRU: begin
                tag = block;
                hit_line = n;
                for (int i = 0; i < n; i++) begin
                    if (hit_line == n && line_live[i] && tag_mem[i] == tag) hit_line = i;
                end
                if (hit_line < n) begin
                    // hit: promote to most recent
                    r = age_rank[hit_line];
                    for (int i = 0; i < n; i++) begin
                        if (line_live[i] && age_rank[i] < r) age_rank[i]++;
                    end
                    age_rank[hit_line] = 0;
                end else begin
                    free_line = n;
                    for (int i = 0; i < n; i++) begin
                        if (free_line == n && !line_live[i]) free_line = i;
                    end
                    if (free_line < n) begin
                        for (int i = 0; i < n; i++) begin
                            if (line_live[i]) age_rank[i]++;
                        end
                        line_live[free_line] = 1'b1;
                        tag_mem[free_line]   = tag;
                        age_rank[free_line]  = 0;
                    end else begin
                        // full: replace the least recent line
                        victim = 0;
                        for (int i = 1; i < n; i++) begin
                            if (age_rank[i] > age_rank[victim]) victim = i;
                        end
                        res.evicted = 1'b1;
                        res.tag     = tag_mem[victim];
                        for (int i = 0; i < n; i++) begin
                            if (i != victim) age_rank[i]++;
                        end
                        tag_mem[victim]  = tag;
                        age_rank[victim] = 0;
                    end
                end
            end
            default: begin
                // disabled mode leaves the store alone
            end
        endcase
    endtask

    // random gap before the next item, mostly short
    function automatic int unsigned pick_gap(input bit steady);
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // address mix: reuse for hits, same-set tags for conflicts, fresh blocks
    function automatic logic [ADDR_W-1:0] next_address();
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] low_mask;
        int unsigned       r;
        r = $urandom_range(0, 99);
        low_mask = (32'h1 << cfg_offset) - 1;
        if (addr_pool.size() != 0 && r < 60) begin
            a = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
            return a ^ ($urandom & low_mask);
        end
        if (addr_pool.size() != 0 && r < 80) begin
            a = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
            a = a ^ ($urandom << (cfg_offset + eff_lines()));
        end else begin
            a = $urandom;
        end
        addr_pool.push_back(a);
        if (addr_pool.size() > 2 * (1 << eff_lines()) + 4) void'(addr_pool.pop_front());
        return a;
    endfunction

    // present one item and wait for it to be taken
    task automatic send_access(input logic [ADDR_W-1:0] addr, input int unsigned gap);
        t_eviction res;
        i_start   <= 1'b1;
        i_address <= addr;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_eviction(addr, res);
        eviction_q.push_back(res);
        items_sent++;
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off until every pending result is back and the block is idle
    task automatic drain_block();
        i_start <= 1'b0;
        while (eviction_q.size() != 0) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register write, block must be idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_MODE: begin
                cfg_mode = data[MODE_W-1:0];
                flush_store();
            end
            CFG_OFFSET: begin
                cfg_offset = data;
                flush_store();
            end
            CFG_LINES: begin
                cfg_lines = data;
                flush_store();
            end
            default: begin
                // unused index: no effect, no flush
            end
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic note_failure(input string what, input logic [TAG_W-1:0] exp_v,
                                input logic [TAG_W-1:0] act_v);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%0t: mismatch on %s: expected %h, got %h", $time, what, exp_v, act_v);
    endtask

    // result checker
    always @(posedge i_clk) begin : result_check
        t_eviction want;
        if (i_rst_n && o_done) begin
            if (eviction_q.size() == 0) begin
                note_failure("unexpected result tag", '0, o_evicted_tag);
            end else begin
                want = eviction_q.pop_front();
                if (o_evicted !== want.evicted)
                    note_failure("evicted", TAG_W'(want.evicted), TAG_W'(o_evicted));
                if (o_evicted_tag !== want.tag) note_failure("evicted_tag", want.tag, o_evicted_tag);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done || i_cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", stall_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // reset defaults, direct mapped: fills, hits inside a block, conflicts
    task automatic test_direct_conflicts();
        send_access(32'h0000_0000, pick_gap(1'b0));
        send_access(32'h0000_0008, pick_gap(1'b0));
        send_access(32'h0000_1000, pick_gap(1'b0));
        send_access(32'h0000_0000, pick_gap(1'b0));
        send_access(32'hFFFF_FFFF, pick_gap(1'b0));
        send_access(32'hFFFF_FFF0, pick_gap(1'b0));
        send_access(32'h7FFF_FFF0, pick_gap(1'b0));
    endtask

    // four-way, one set, byte blocks: fill, hit without reorder, fifo eviction
    task automatic test_four_way_fifo();
        drain_block();
        write_reg(CFG_MODE, {2'b00, MODE_FIFO4});
        write_reg(CFG_LINES, 4'd0);
        write_reg(CFG_OFFSET, 4'd0);
        send_access(32'h10, pick_gap(1'b0));
        send_access(32'h20, pick_gap(1'b0));
        send_access(32'h30, pick_gap(1'b0));
        send_access(32'h40, pick_gap(1'b0));
        send_access(32'h20, pick_gap(1'b0));
        send_access(32'h50, pick_gap(1'b0));
        send_access(32'h60, pick_gap(1'b0));
    endtask

    // fully associative, four lines, offset above twelve; unused index keeps contents
    task automatic test_lru_recency();
        drain_block();
        write_reg(CFG_MODE, {2'b00, MODE_LRU});
        write_reg(CFG_LINES, 4'd1);
        write_reg(CFG_OFFSET, 4'd15);
        for (int k = 1; k <= 4; k++) send_access(k << 15, pick_gap(1'b0));
        send_access(32'h1 << 15, pick_gap(1'b0));
        send_access(32'h5 << 15, pick_gap(1'b0));
        send_access(32'h6 << 15, pick_gap(1'b0));
        drain_block();
        write_reg(CFG_UNUSED, 4'hF);
        send_access(32'h1 << 15, pick_gap(1'b0));
    endtask

    // mode three with line count above range
    task automatic test_disabled_mode();
        drain_block();
        write_reg(CFG_MODE, {2'b11, MODE_OFF});
        write_reg(CFG_LINES, 4'd15);
        send_access(32'hFFFF_FFFF, pick_gap(1'b0));
        send_access(32'h0000_0000, pick_gap(1'b0));
    endtask

    // phases of random settings and traffic, a few with the full line count
    task automatic test_random_traffic();
        int unsigned       phase;
        int unsigned       quota;
        int unsigned       target;
        logic [MODE_W-1:0] mode;
        logic [1:0]        upper;
        logic [OFS_W-1:0]  lines_raw;
        logic [OFS_W-1:0]  offset;
        bit                steady;
        phase  = 0;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            if (phase == 3 || phase == 9) begin
                mode      = MODE_LRU;
                lines_raw = (phase == 3) ? 4'd8 : 4'd15;
                quota     = (phase == 3) ? 20 : 16;
            end else begin
                mode = ($urandom_range(0, 15) == 0) ? MODE_OFF : MODE_W'($urandom_range(0, 2));
                if (mode == MODE_LRU) lines_raw = OFS_W'($urandom_range(0, 4));
                else lines_raw = OFS_W'($urandom_range(0, 15));
                quota = (mode == MODE_OFF) ? 8 : $urandom_range(40, 90);
            end
            case ($urandom_range(0, 5))
                0:       offset = 4'd0;
                1:       offset = 4'd15;
                2:       offset = 4'd12;
                default: offset = OFS_W'($urandom_range(0, 15));
            endcase
            upper  = 2'($urandom_range(0, 3));
            steady = ($urandom_range(0, 3) == 0);
            drain_block();
            write_reg(CFG_MODE, {upper, mode});
            write_reg(CFG_OFFSET, offset);
            write_reg(CFG_LINES, lines_raw);
            if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 15)));
            addr_pool.delete();
            for (int k = 0; k < quota; k++) begin
                send_access(next_address(), pick_gap(steady));
                // occasional full drain in the middle of a phase
                if ($urandom_range(0, 79) == 0) drain_block();
            end
            phase++;
        end
    endtask

    initial begin
        flush_store();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_direct_conflicts();
        test_four_way_fifo();
        test_lru_recency();
        test_disabled_mode();
        test_random_traffic();
        drain_block();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && eviction_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* files.f */
sv/ctr_pkg.sv
sv/ctr_ram.sv
sv/ctr_scan.sv
sv/cache_tag_replacement_model.sv
dv/tb_top.sv
